>>> rtl/csp_pkg.sv
// Shared definitions for the call stack profiler: field widths, action codes,
// and the command and status words passed between controller and datapath.
// No dependencies.
package csp_pkg;

   localparam int ACTION_W = 2;
   localparam int FUNC_W = 8;
   localparam int TIME_W = 48;
   localparam int COUNT_W = 32;
   localparam int TOTAL_W = 64;
   localparam int DEPTH_W = 16;

   // Counter table covers every function id
   localparam int FUNCTION_COUNT = 256;

   localparam logic [DEPTH_W-1:0] DEPTH_MAX = {DEPTH_W{1'b1}};

   // Action codes; code 3 behaves as a read
   localparam logic [ACTION_W-1:0] ACT_ENTER = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_LEAVE = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_READ = 2'd2;

   typedef struct packed {
      logic accept;  // take the request word, update depth, start memory reads
      logic step;    // stack entry is ready: form elapsed, read its counters
      logic finish;  // counters ready: write back, load the response word
   } csp_cmd_type;

   typedef struct packed {
      logic stack_hit;  // a leave now would pop a level held in the stack
   } csp_status_type;

endpackage

>>> rtl/csp_ctrl.sv
// Sequencing controller of the call stack profiler.
// Drives csp_cmd_type commands to csp_dpath; uses csp_pkg.
module csp_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic [csp_pkg::ACTION_W-1:0] req_action,
   output logic                    req_stall,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   input  csp_pkg::csp_status_type status,
   output csp_pkg::csp_cmd_type    cmd
);
   import csp_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_STACK,
      ST_COUNT
   } state_type;

   state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      cmd = '0;
      state_in = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               if (req_action == ACT_LEAVE && status.stack_hit) begin
                  state_in = ST_STACK;
               end else begin
                  state_in = ST_COUNT;
               end
            end
         end
         ST_STACK: begin
            cmd.step = 1'b1;
            state_in = ST_COUNT;
         end
         ST_COUNT: begin
            if (out_free) begin
               cmd.finish = 1'b1;
               rsp_valid_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

`ifndef SYNTH
   a_finish_free: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> !(rsp_valid_ff && rsp_stall))
      else $error("response loaded over a stalled word");
   a_hit_goes_stack: assert property (@(posedge clock) disable iff (reset)
      (cmd.accept && req_action == ACT_LEAVE && status.stack_hit) |=> state_ff == ST_STACK)
      else $error("stacked leave skipped the stack read");
   a_rsp_from_count: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_COUNT))
      else $error("response raised outside the counter step");
`endif

endmodule

>>> rtl/csp_dpath.sv
// Datapath of the call stack profiler: depth counter, call stack memory,
// per-function counter memory and response registers. Uses csp_pkg.
module csp_dpath #(
   parameter int STACK_LEVELS = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  csp_pkg::csp_cmd_type          cmd,
   output csp_pkg::csp_status_type       status,
   input  logic [csp_pkg::ACTION_W-1:0]  req_action,
   input  logic [csp_pkg::FUNC_W-1:0]    req_function_id,
   input  logic [csp_pkg::TIME_W-1:0]    req_timestamp,
   output logic                          rsp_accounted,
   output logic [csp_pkg::FUNC_W-1:0]    rsp_result_function,
   output logic [csp_pkg::TIME_W-1:0]    rsp_elapsed,
   output logic [csp_pkg::COUNT_W-1:0]   rsp_call_count,
   output logic [csp_pkg::TOTAL_W-1:0]   rsp_elapsed_total,
   output logic [csp_pkg::DEPTH_W-1:0]   rsp_nesting_depth
);
   import csp_pkg::*;

   localparam int STACK_AW = (STACK_LEVELS > 1) ? $clog2(STACK_LEVELS) : 1;
   localparam int STACK_EW = FUNC_W + TIME_W;
   localparam int CNT_EW = COUNT_W + TOTAL_W;
   localparam logic [DEPTH_W-1:0] STACK_TOP = DEPTH_W'(STACK_LEVELS);

   typedef enum logic [1:0] {
      KIND_REPORT,
      KIND_HIT,
      KIND_MISS
   } kind_type;

   logic [DEPTH_W-1:0] depth_ff, depth_in, depth_dec;
   kind_type kind_ff, kind_in;
   logic [FUNC_W-1:0] fid_ff, fid_in;
   logic [TIME_W-1:0] ts_ff;
   logic [TIME_W-1:0] elapsed_ff;

   logic [STACK_EW-1:0] stack_mem [STACK_LEVELS];
   logic [STACK_EW-1:0] stack_rd_ff;
   logic [CNT_EW-1:0] cnt_mem [FUNCTION_COUNT];
   logic [CNT_EW-1:0] cnt_rd_ff;
   logic [FUNCTION_COUNT-1:0] cnt_valid_ff;
   logic cnt_rd_valid_ff;

   logic is_enter, is_leave, stack_room, stack_hit, cnt_we, cnt_rd;
   logic [STACK_AW-1:0] stack_wr_addr, stack_rd_addr;
   logic [FUNC_W-1:0] stack_fn, cnt_rd_addr;
   logic [COUNT_W-1:0] cur_count, new_count;
   logic [TOTAL_W-1:0] cur_total, new_total;

   logic accounted_ff, accounted_in;
   logic [FUNC_W-1:0] fn_out_ff, fn_out_in;
   logic [TIME_W-1:0] el_out_ff, el_out_in;
   logic [COUNT_W-1:0] count_out_ff, count_out_in;
   logic [TOTAL_W-1:0] total_out_ff, total_out_in;
   logic [DEPTH_W-1:0] depth_out_ff;

   assign is_enter = (req_action == ACT_ENTER);
   assign is_leave = (req_action == ACT_LEAVE);
   assign depth_dec = depth_ff - 1'b1;
   assign stack_room = (depth_ff < STACK_TOP);
   assign stack_hit = (depth_ff != '0) && (depth_ff <= STACK_TOP);
   assign status.stack_hit = stack_hit;

   assign stack_wr_addr = depth_ff[STACK_AW-1:0];
   assign stack_rd_addr = depth_dec[STACK_AW-1:0];
   assign stack_fn = stack_rd_ff[STACK_EW-1:TIME_W];

   assign cnt_rd_addr = cmd.step ? stack_fn : req_function_id;
   assign cnt_rd = cmd.accept || cmd.step;
   assign cnt_we = cmd.finish && (kind_ff == KIND_HIT);

   // unwritten entries read as zero
   assign cur_count = cnt_rd_valid_ff ? cnt_rd_ff[CNT_EW-1:TOTAL_W] : '0;
   assign cur_total = cnt_rd_valid_ff ? cnt_rd_ff[TOTAL_W-1:0] : '0;
   assign new_count = cur_count + 1'b1;
   assign new_total = cur_total + TOTAL_W'(elapsed_ff);

   always_comb begin
      depth_in = depth_ff;
      if (cmd.accept) begin
         if (is_enter && depth_ff != DEPTH_MAX) begin
            depth_in = depth_ff + 1'b1;
         end else if (is_leave && depth_ff != '0) begin
            depth_in = depth_dec;
         end
      end
   end

   always_comb begin
      kind_in = kind_ff;
      fid_in = fid_ff;
      if (cmd.accept) begin
         fid_in = req_function_id;
         if (!is_leave) begin
            kind_in = KIND_REPORT;
         end else if (stack_hit) begin
            kind_in = KIND_HIT;
         end else begin
            kind_in = KIND_MISS;
         end
      end else if (cmd.step) begin
         fid_in = stack_fn;
      end
   end

   always_comb begin
      case (kind_ff)
         KIND_HIT: begin
            accounted_in = 1'b1;
            fn_out_in = fid_ff;
            el_out_in = elapsed_ff;
            count_out_in = new_count;
            total_out_in = new_total;
         end
         KIND_MISS: begin
            accounted_in = 1'b0;
            fn_out_in = '0;
            el_out_in = '0;
            count_out_in = '0;
            total_out_in = '0;
         end
         default: begin
            accounted_in = 1'b0;
            fn_out_in = fid_ff;
            el_out_in = '0;
            count_out_in = cur_count;
            total_out_in = cur_total;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff <= '0;
         cnt_valid_ff <= '0;
      end else begin
         depth_ff <= depth_in;
         if (cnt_we) begin
            cnt_valid_ff[fid_ff] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
      fid_ff <= fid_in;
      if (cmd.accept) begin
         ts_ff <= req_timestamp;
      end
      if (cmd.step) begin
         elapsed_ff <= ts_ff - stack_rd_ff[TIME_W-1:0];
      end
      if (cnt_rd) begin
         cnt_rd_valid_ff <= cnt_valid_ff[cnt_rd_addr];
      end
      if (cmd.finish) begin
         accounted_ff <= accounted_in;
         fn_out_ff <= fn_out_in;
         el_out_ff <= el_out_in;
         count_out_ff <= count_out_in;
         total_out_ff <= total_out_in;
         depth_out_ff <= depth_ff;
      end
   end

   // call stack memory
   always_ff @(posedge clock) begin
      if (cmd.accept && is_enter && stack_room) begin
         stack_mem[stack_wr_addr] <= {req_function_id, req_timestamp};
      end
      if (cmd.accept && is_leave && stack_hit) begin
         stack_rd_ff <= stack_mem[stack_rd_addr];
      end
   end

   // per-function counter memory
   always_ff @(posedge clock) begin
      if (cnt_we) begin
         cnt_mem[fid_ff] <= {new_count, new_total};
      end
      if (cnt_rd) begin
         cnt_rd_ff <= cnt_mem[cnt_rd_addr];
      end
   end

   assign rsp_accounted = accounted_ff;
   assign rsp_result_function = fn_out_ff;
   assign rsp_elapsed = el_out_ff;
   assign rsp_call_count = count_out_ff;
   assign rsp_elapsed_total = total_out_ff;
   assign rsp_nesting_depth = depth_out_ff;

`ifndef SYNTH
   a_depth_hold: assert property (@(posedge clock) disable iff (reset)
      !cmd.accept |=> $stable(depth_ff))
      else $error("depth moved without a request word");
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (cmd.finish && kind_ff == KIND_MISS) |=>
         (rsp_call_count == '0 && rsp_elapsed_total == '0 && !rsp_accounted))
      else $error("unstacked leave reported counters");
`endif

endmodule

>>> rtl/call_stack_profiler.sv
// Call stack profiler top level. Every request word returns exactly one
// response word. An enter (action 0) pushes the function id and timestamp onto
// a stack of STACK_LEVELS entries and reports that function's counters; the
// nesting depth keeps counting past the stack and saturates at 65535. A leave
// (action 1) at depth zero or beyond the stack only moves the depth and reports
// zeros; otherwise it pops the level, forms elapsed = leave time - enter time
// (mod 2^48), adds one call and the elapsed time to the function's wrapping
// counters and reports the updated values with accounted set. A read (action 2,
// code 3 alike) reports a function's counters. An enter or read passes from
// acceptance to the counter step and the response; a leave that pops a stacked
// level passes the stack step first, since its counter address comes out of
// the registered stack memory read before the registered counter memory read.
// One word is in work at a time; req_stall stays high until it is loaded into
// the response register, which then waits on rsp_stall while the next request
// word is taken. Counters read as zero after reset through one valid bit per
// function, so reset needs no clearing pass and words are accepted right after.
// Sub-blocks: csp_ctrl (sequencer), csp_dpath (memories and arithmetic).
module call_stack_profiler #(
   parameter int STACK_LEVELS = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [csp_pkg::ACTION_W-1:0]  req_action,
   input  logic [csp_pkg::FUNC_W-1:0]    req_function_id,
   input  logic [csp_pkg::TIME_W-1:0]    req_timestamp,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_accounted,
   output logic [csp_pkg::FUNC_W-1:0]    rsp_result_function,
   output logic [csp_pkg::TIME_W-1:0]    rsp_elapsed,
   output logic [csp_pkg::COUNT_W-1:0]   rsp_call_count,
   output logic [csp_pkg::TOTAL_W-1:0]   rsp_elapsed_total,
   output logic [csp_pkg::DEPTH_W-1:0]   rsp_nesting_depth
);
   import csp_pkg::*;

   csp_cmd_type cmd;
   csp_status_type status;

   // sequencer: accept, optional stack step, then finish into the response reg
   csp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_action (req_action),
      .req_stall  (req_stall),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .status     (status),
      .cmd        (cmd)
   );

   // depth, stack and counter memories, response payload
   csp_dpath #(
      .STACK_LEVELS (STACK_LEVELS)
   ) u_dpath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .req_action          (req_action),
      .req_function_id     (req_function_id),
      .req_timestamp       (req_timestamp),
      .rsp_accounted       (rsp_accounted),
      .rsp_result_function (rsp_result_function),
      .rsp_elapsed         (rsp_elapsed),
      .rsp_call_count      (rsp_call_count),
      .rsp_elapsed_total   (rsp_elapsed_total),
      .rsp_nesting_depth   (rsp_nesting_depth)
   );

endmodule
